### design/tpi_pkg.sv
// Shared constants and register index codes for the triangle/plane intersection block.
package tpi_pkg;

   localparam int DEFAULT_COORD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int ONE_Q16             = 65536;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PLANE_POINT_X = 3'd0,
      CSR_PLANE_POINT_Y = 3'd1,
      CSR_PLANE_POINT_Z = 3'd2,
      CSR_NORMAL_X      = 3'd3,
      CSR_NORMAL_Y      = 3'd4,
      CSR_NORMAL_Z      = 3'd5
   } csr_index_type;

   // Bit positions of the pending-point mask of one triangle, in emission order.
   localparam int JOB_CROSS_12 = 0;
   localparam int JOB_CROSS_13 = 1;
   localparam int JOB_CROSS_23 = 2;
   localparam int JOB_VERTEX_1 = 3;
   localparam int JOB_VERTEX_2 = 4;
   localparam int JOB_VERTEX_3 = 5;
   localparam int JOB_COUNT    = 6;

endpackage

### design/triangle_plane_intersection_top.sv
// Pipelined triangle/plane intersection: distances, point expansion, crossing divider.
// Points flow through the triangle pipeline, expansion stage, point pipeline and divider.
// Throughput: one triangle per cycle while each gives at most one point and the output
// is not stalled; a triangle with more points holds the expansion stage, one per cycle out.
// The divider is a restoring pipeline of COORD_WIDTH + 1 one-bit stages per axis.
// Reset clears all valid bits and loads the plane registers with their reset values.
module triangle_plane_intersection_top
   import tpi_pkg::*;
#(
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  logic signed [COORD_WIDTH-1:0] req_third_x,
   input  logic signed [COORD_WIDTH-1:0] req_third_y,
   input  logic signed [COORD_WIDTH-1:0] req_third_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_z,
   output logic                          rsp_last_of_face,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_data
);

   localparam int CW   = COORD_WIDTH;
   localparam int PW   = 2 * CW + 1;   // one product of the dot product
   localparam int DW   = 2 * CW + 3;   // signed distance
   localparam int AW   = 2 * CW + 2;   // distance magnitude
   localparam int MW   = CW + 1;       // edge extent magnitude, half of AW
   localparam int PPW  = 2 * MW;       // partial product
   localparam int NW   = 3 * CW + 4;   // dividend
   localparam int DENW = AW + 2;       // divisor
   localparam int QW   = CW + 1;       // quotient
   localparam logic [CW-1:0] NORMAL_Z_RESET = CW'(ONE_Q16);

   // Plane registers.
   logic signed [CW-1:0] point_ff  [0:2];
   logic signed [CW-1:0] normal_ff [0:2];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff[0]  <= '0;
         point_ff[1]  <= '0;
         point_ff[2]  <= '0;
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= NORMAL_Z_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PLANE_POINT_X: point_ff[0]  <= csr_data;
            CSR_PLANE_POINT_Y: point_ff[1]  <= csr_data;
            CSR_PLANE_POINT_Z: point_ff[2]  <= csr_data;
            CSR_NORMAL_X:      normal_ff[0] <= csr_data;
            CSR_NORMAL_Y:      normal_ff[1] <= csr_data;
            CSR_NORMAL_Z:      normal_ff[2] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   logic signed [CW-1:0] vin [0:2][0:2];
   assign vin[0][0] = req_first_x;
   assign vin[0][1] = req_first_y;
   assign vin[0][2] = req_first_z;
   assign vin[1][0] = req_second_x;
   assign vin[1][1] = req_second_y;
   assign vin[1][2] = req_second_z;
   assign vin[2][0] = req_third_x;
   assign vin[2][1] = req_third_y;
   assign vin[2][2] = req_third_z;

   // Triangle pipeline: differences, products, distances, signs.
   logic                 tri_en;
   logic                 adv;
   logic                 t1_valid_ff, t2_valid_ff, t3_valid_ff, t4_valid_ff;
   logic signed [CW-1:0] t1_v_ff [0:2][0:2];
   logic signed [CW-1:0] t2_v_ff [0:2][0:2];
   logic signed [CW-1:0] t3_v_ff [0:2][0:2];
   logic signed [CW-1:0] t4_v_ff [0:2][0:2];
   logic signed [CW:0]   t1_diff_ff [0:2][0:2];
   logic signed [PW-1:0] t2_prod_ff [0:2][0:2];
   logic signed [DW-1:0] t3_dist_ff [0:2];
   logic [AW-1:0]        t4_abs_ff [0:2];
   logic [JOB_COUNT-1:0] t4_mask_ff;

   logic [DW-1:0]        dist_mag [0:2];
   logic [2:0]           d_neg, d_zero, d_pos;
   logic [JOB_COUNT-1:0] mask_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_neg[k]    = t3_dist_ff[k][DW-1];
         d_zero[k]   = (t3_dist_ff[k] == '0);
         d_pos[k]    = !d_neg[k] && !d_zero[k];
         dist_mag[k] = d_neg[k] ? DW'(-t3_dist_ff[k]) : DW'(t3_dist_ff[k]);
      end
      mask_in = '0;
      if (!(&d_neg) && !(&d_pos)) begin
         mask_in[JOB_CROSS_12] = (d_neg[0] && d_pos[1]) || (d_pos[0] && d_neg[1]);
         mask_in[JOB_CROSS_13] = (d_neg[0] && d_pos[2]) || (d_pos[0] && d_neg[2]);
         mask_in[JOB_CROSS_23] = (d_neg[1] && d_pos[2]) || (d_pos[1] && d_neg[2]);
         mask_in[JOB_VERTEX_1] = d_zero[0];
         mask_in[JOB_VERTEX_2] = d_zero[1];
         mask_in[JOB_VERTEX_3] = d_zero[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
         t4_valid_ff <= 1'b0;
      end else if (tri_en) begin
         t1_valid_ff <= req_valid;
         t2_valid_ff <= t1_valid_ff;
         t3_valid_ff <= t2_valid_ff;
         t4_valid_ff <= t3_valid_ff;
      end
      if (tri_en) begin
         for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
               t1_v_ff[k][a]    <= vin[k][a];
               t1_diff_ff[k][a] <= (CW+1)'(vin[k][a]) - (CW+1)'(point_ff[a]);
               t2_v_ff[k][a]    <= t1_v_ff[k][a];
               t2_prod_ff[k][a] <= PW'(t1_diff_ff[k][a] * normal_ff[a]);
               t3_v_ff[k][a]    <= t2_v_ff[k][a];
               t4_v_ff[k][a]    <= t3_v_ff[k][a];
            end
            t3_dist_ff[k] <= DW'(t2_prod_ff[k][0]) + DW'(t2_prod_ff[k][1])
                           + DW'(t2_prod_ff[k][2]);
            t4_abs_ff[k]  <= dist_mag[k][AW-1:0];
         end
         t4_mask_ff <= mask_in;
      end
   end

   // Expansion stage: holds one triangle, hands out its points one per cycle unless stalled.
   logic [JOB_COUNT-1:0] h_mask_ff;
   logic signed [CW-1:0] h_v_ff [0:2][0:2];
   logic [AW-1:0]        h_abs_ff [0:2];
   logic [JOB_COUNT-1:0] h_rest, h_low;
   logic [1:0]           sel_i, sel_j;
   logic                 sel_vtx;
   logic signed [CW:0]   edge_d [0:2];

   assign adv     = !rsp_valid || rsp_ready;
   assign tri_en  = (h_mask_ff == '0) || (adv && $onehot(h_mask_ff));
   assign req_ready = tri_en;
   assign h_rest  = h_mask_ff & (h_mask_ff - 1'b1);
   assign h_low   = h_mask_ff ^ h_rest;

   always_comb begin
      sel_vtx = 1'b0;
      sel_i   = 2'd0;
      sel_j   = 2'd1;
      if (h_low[JOB_CROSS_13]) begin
         sel_j = 2'd2;
      end else if (h_low[JOB_CROSS_23]) begin
         sel_i = 2'd1;
         sel_j = 2'd2;
      end else if (h_low[JOB_VERTEX_1]) begin
         sel_vtx = 1'b1;
      end else if (h_low[JOB_VERTEX_2]) begin
         sel_vtx = 1'b1;
         sel_i   = 2'd1;
      end else if (h_low[JOB_VERTEX_3]) begin
         sel_vtx = 1'b1;
         sel_i   = 2'd2;
      end
      for (int a = 0; a < 3; a++) begin
         edge_d[a] = (CW+1)'(h_v_ff[sel_j][a]) - (CW+1)'(h_v_ff[sel_i][a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_mask_ff <= '0;
      end else if (tri_en) begin
         h_mask_ff <= t4_valid_ff ? t4_mask_ff : '0;
      end else if (adv) begin
         h_mask_ff <= h_rest;
      end
      if (tri_en) begin
         h_v_ff   <= t4_v_ff;
         h_abs_ff <= t4_abs_ff;
      end
   end

   // Point pipeline: partial products, dividend, divider, output.
   logic                 p1_valid_ff, p1_vtx_ff, p1_last_ff;
   logic [AW-1:0]        p1_ai_ff;
   logic [AW:0]          p1_s_ff;
   logic [MW-1:0]        p1_mag_ff [0:2];
   logic [2:0]           p1_neg_ff;
   logic signed [CW-1:0] p1_vi_ff [0:2];

   logic                 p2_valid_ff, p2_vtx_ff, p2_last_ff;
   logic [AW:0]          p2_s_ff;
   logic [PPW-1:0]       p2_pplo_ff [0:2];
   logic [PPW-1:0]       p2_pphi_ff [0:2];
   logic [2:0]           p2_neg_ff;
   logic signed [CW-1:0] p2_vi_ff [0:2];

   logic                 dv_valid_ff [0:QW];
   logic                 dv_vtx_ff   [0:QW];
   logic                 dv_last_ff  [0:QW];
   logic [2:0]           dv_neg_ff   [0:QW];
   logic signed [CW-1:0] dv_vi_ff    [0:QW][0:2];
   logic [DENW-1:0]      dv_den_ff   [0:QW];
   logic [NW-1:0]        dv_num_ff   [0:QW][0:2];
   logic [DENW-1:0]      dv_rem_ff   [0:QW][0:2];
   logic [QW-1:0]        dv_q_ff     [0:QW][0:2];

   logic [NW-1:0]        num_in   [0:2];
   logic [DENW:0]        trial    [0:QW-1][0:2];
   logic [DENW:0]        trial_d  [0:QW-1][0:2];
   logic                 trial_ge [0:QW-1][0:2];
   logic signed [CW-1:0] hit_in   [0:2];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         num_in[a] = {p2_pphi_ff[a], (CW+2)'(0)} + NW'({p2_pplo_ff[a], 1'b0})
                   + NW'(p2_s_ff);
         hit_in[a] = dv_vi_ff[QW][a];
         if (!dv_vtx_ff[QW]) begin
            hit_in[a] = dv_neg_ff[QW][a] ? dv_vi_ff[QW][a] - dv_q_ff[QW][a][CW-1:0]
                                         : dv_vi_ff[QW][a] + dv_q_ff[QW][a][CW-1:0];
         end
      end
      for (int k = 0; k < QW; k++) begin
         for (int a = 0; a < 3; a++) begin
            trial[k][a]    = {dv_rem_ff[k][a], dv_num_ff[k][a][QW-1-k]};
            trial_d[k][a]  = trial[k][a] - {1'b0, dv_den_ff[k]};
            trial_ge[k][a] = (trial[k][a] >= {1'b0, dv_den_ff[k]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
         for (int k = 0; k <= QW; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         p1_valid_ff    <= (h_mask_ff != '0);
         p2_valid_ff    <= p1_valid_ff;
         dv_valid_ff[0] <= p2_valid_ff;
         for (int k = 0; k < QW; k++) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
         rsp_valid <= dv_valid_ff[QW];
      end
      if (adv) begin
         p1_vtx_ff  <= sel_vtx;
         p1_last_ff <= (h_rest == '0);
         p1_ai_ff   <= h_abs_ff[sel_i];
         p1_s_ff    <= (AW+1)'(h_abs_ff[sel_i]) + (AW+1)'(h_abs_ff[sel_j]);
         for (int a = 0; a < 3; a++) begin
            p1_neg_ff[a] <= edge_d[a][CW];
            p1_mag_ff[a] <= edge_d[a][CW] ? MW'(-edge_d[a]) : MW'(edge_d[a]);
            p1_vi_ff[a]  <= h_v_ff[sel_i][a];
         end

         p2_vtx_ff  <= p1_vtx_ff;
         p2_last_ff <= p1_last_ff;
         p2_s_ff    <= p1_s_ff;
         p2_neg_ff  <= p1_neg_ff;
         for (int a = 0; a < 3; a++) begin
            p2_pplo_ff[a] <= p1_ai_ff[MW-1:0] * p1_mag_ff[a];
            p2_pphi_ff[a] <= p1_ai_ff[AW-1:MW] * p1_mag_ff[a];
            p2_vi_ff[a]   <= p1_vi_ff[a];
         end

         dv_vtx_ff[0]  <= p2_vtx_ff;
         dv_last_ff[0] <= p2_last_ff;
         dv_neg_ff[0]  <= p2_neg_ff;
         dv_den_ff[0]  <= {p2_s_ff, 1'b0};
         for (int a = 0; a < 3; a++) begin
            dv_vi_ff[0][a]  <= p2_vi_ff[a];
            dv_num_ff[0][a] <= num_in[a];
            dv_rem_ff[0][a] <= DENW'(num_in[a][NW-1:QW]);
            dv_q_ff[0][a]   <= '0;
         end

         for (int k = 0; k < QW; k++) begin
            dv_vtx_ff[k+1]  <= dv_vtx_ff[k];
            dv_last_ff[k+1] <= dv_last_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_den_ff[k+1]  <= dv_den_ff[k];
            for (int a = 0; a < 3; a++) begin
               dv_vi_ff[k+1][a]  <= dv_vi_ff[k][a];
               dv_num_ff[k+1][a] <= dv_num_ff[k][a];
               dv_rem_ff[k+1][a] <= trial_ge[k][a] ? trial_d[k][a][DENW-1:0]
                                                   : trial[k][a][DENW-1:0];
               dv_q_ff[k+1][a]   <= {dv_q_ff[k][a][QW-2:0], trial_ge[k][a]};
            end
         end

         rsp_hit_x        <= hit_in[0];
         rsp_hit_y        <= hit_in[1];
         rsp_hit_z        <= hit_in[2];
         rsp_last_of_face <= dv_last_ff[QW];
      end
   end

`ifndef SYNTHESIS
   // A triangle never asks for more than three points.
   assert property (@(posedge clock) disable iff (reset) $countones(h_mask_ff) <= 3)
      else $error("expansion stage holds more than three points");

   // Pending points stay put while the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (h_mask_ff != '0 && !adv) |=> $stable(h_mask_ff))
      else $error("pending points changed during a stall");

   // The points of one face leave back to back.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_face) |=> rsp_valid)
      else $error("gap inside the points of one face");
`endif

endmodule
